// ===== design/softmax_vector_core_macros.svh =====
// Assertion macros used by the checker file of softmax_vector_core.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef SOFTMAX_VECTOR_CORE_MACROS_SVH
`define SOFTMAX_VECTOR_CORE_MACROS_SVH

// Clocked assertion, masked while reset is applied
`define SMX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication held over the next clock edge
`define SMX_ASSERT_NEXT(lbl, ante, cons, msg) \
  `SMX_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== design/smx_pkg.sv =====
// Shared types, widths and constant tables of the softmax vector core.
// Depends on nothing; used by every module of the block but smx_ram and smx_checker.
package smx_pkg;

  localparam int MAX_LEN   = 16;
  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int LOGIT_W   = 16;
  localparam int PROB_W    = 16;
  localparam int EXP_W     = 28;
  localparam int SUM_W     = 34;
  localparam int FRAC_W    = 11;
  localparam int ROM_DEPTH = 2 ** FRAC_W;
  localparam int ROM_W     = 42;
  localparam int V_W       = 54;
  localparam int CONST_W   = 62;
  localparam int HALF_V    = 26;
  localparam int HALF_C    = 31;
  localparam int PP_W      = HALF_V + HALF_C;
  localparam int ACC_W     = 2 * HALF_V + CONST_W;
  localparam int NUM_W     = EXP_W + PROB_W + 1;
  localparam int QUO_W     = PROB_W + 1;
  localparam int DIV_W     = SUM_W + PROB_W + 1;

  localparam logic [63:0]    Q60_ONE = 64'd1 << 60;
  localparam logic [EXP_W-1:0] EXP_MAX = '1;

  // Queue entry passed from the front to the back
  typedef struct packed {
    logic [LOGIT_W-1:0] logit;
    logic               last;
    logic               drop;
  } smx_entry_t;

  typedef logic [ROM_W-1:0] exp_rom_t [ROM_DEPTH];

  // (a * b) >> 60, kept to 64 bits
  function automatic logic [63:0] mul_shr60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[123:60];
  endfunction

  // Taylor series of exp(t) or exp(-t), Q4.60, elaboration only
  function automatic logic [63:0] series_q60(logic [63:0] t, logic alt);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    pos  = Q60_ONE;
    neg  = '0;
    term = Q60_ONE;
    for (int n = 1; n <= 30; n++) begin
      term = mul_shr60(term, t) / 64'(n);
      if (alt && n[0]) neg = neg + term;
      else             pos = pos + term;
    end
    return pos - neg;
  endfunction

  // exp(f/2048) in Q40 for every fraction code
  function automatic exp_rom_t build_rom();
    exp_rom_t rom;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      rom[i] = ROM_W'(series_q60(64'(i) << 49, 1'b0) >> 20);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_rom();
  localparam logic [CONST_W-1:0] E_Q60    = CONST_W'(series_q60(Q60_ONE, 1'b0));
  localparam logic [CONST_W-1:0] EINV_Q60 = CONST_W'(series_q60(Q60_ONE, 1'b1));

endpackage

// ===== design/smx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module smx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/smx_front.sv =====
// Front end: accepts logits, counts the vector and marks dropped elements,
// then holds them in a two-entry queue for the back end. Uses smx_pkg.
module smx_front import smx_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [LOGIT_W-1:0] logit_i,
  input  logic               last_in_i,
  output logic               q_valid_o,
  output smx_entry_t         q_entry_o,
  input  logic               q_pop_i
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  smx_entry_t       mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fill_q, fill_d;
  logic             accept, drop;

  assign in_stall_o = (fill_q == 2'd2);
  assign accept     = in_valid_i && !in_stall_o;
  assign drop       = (cnt_q >= CNT_W'(MAX_LEN));
  assign q_valid_o  = (fill_q != 2'd0);
  assign q_entry_o  = mem_q[rd_ptr_q];

  // Element count of the vector being loaded
  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (last_in_i) cnt_d = '0;
      else if (!drop) cnt_d = cnt_q + 1'b1;
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (accept && !(q_pop_i && q_valid_o)) fill_d = fill_q + 1'b1;
    else if (!accept && q_pop_i && q_valid_o) fill_d = fill_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      fill_q   <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      fill_q <= fill_d;
      if (accept) wr_ptr_q <= !wr_ptr_q;
      if (q_pop_i && q_valid_o) rd_ptr_q <= !rd_ptr_q;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (accept) mem_q[wr_ptr_q] <= '{logit: logit_i, last: last_in_i, drop: drop};
  end

endmodule

// ===== design/smx_exp.sv =====
// Exponential unit: fraction table lookup, then repeated products by e or
// 1/e on a shared 26x31 multiplier, four partial products each. Uses smx_pkg.
module smx_exp import smx_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [LOGIT_W-1:0] logit_i,
  output logic               done_o,
  output logic [EXP_W-1:0]   exp_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ROM  = 4'b0010,
    S_MUL  = 4'b0100,
    S_FIN  = 4'b1000
  } exp_state_e;

  exp_state_e          state_q, state_d;
  logic [FRAC_W-1:0]   f_q;
  logic                pos_q;
  logic [4:0]          rem_q, rem_d;
  logic [1:0]          ph_q, ph_d;
  logic [V_W-1:0]      v_q, v_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [LOGIT_W-1:0]  u;
  logic [HALF_V-1:0]   vh;
  logic [HALF_C-1:0]   ch;
  logic [CONST_W-1:0]  cval;
  logic [PP_W-1:0]     pp;
  logic [ACC_W-1:0]    pp_sh;
  logic [6:0]          shamt;
  logic                big;
  logic [V_W:0]        rnd;
  logic [V_W-24:0]     r;
  logic [EXP_W-1:0]    res;

  // Offset binary splits the logit into integer and fraction parts
  assign u = logit_i ^ {1'b1, {(LOGIT_W-1){1'b0}}};

  // Partial product selection
  assign cval  = pos_q ? E_Q60 : EINV_Q60;
  assign vh    = ph_q[0] ? v_q[2*HALF_V-1:HALF_V] : v_q[HALF_V-1:0];
  assign ch    = ph_q[1] ? cval[2*HALF_C-1:HALF_C] : cval[HALF_C-1:0];
  assign pp    = PP_W'(vh) * PP_W'(ch);
  assign shamt = (ph_q[0] ? 7'(HALF_V) : 7'd0) + (ph_q[1] ? 7'(HALF_C) : 7'd0);
  assign pp_sh = ACC_W'(pp) << shamt;
  assign big   = (v_q[V_W-1:52] != '0);

  // Rounding to Q12.16 with saturation
  assign rnd = (V_W+1)'(v_q) + (V_W+1)'(24'h800000);
  assign r   = rnd[V_W:24];
  assign res = (big || (r[V_W-24:EXP_W] != '0)) ? EXP_MAX : r[EXP_W-1:0];

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    ph_d    = ph_q;
    v_d     = v_q;
    acc_d   = acc_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_ROM;
          rem_d   = u[LOGIT_W-1] ? {1'b0, u[LOGIT_W-2:FRAC_W]}
                                 : 5'd16 - u[LOGIT_W-1:FRAC_W];
        end
      end
      S_ROM: begin
        v_d     = V_W'(EXP_ROM[f_q]);
        ph_d    = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        if (ph_q == 2'd0 && (rem_q == '0 || big)) begin
          state_d = S_FIN;
        end else begin
          acc_d = ((ph_q == 2'd0) ? '0 : acc_q) + pp_sh;
          ph_d  = ph_q + 1'b1;
          if (ph_q == 2'd3) begin
            v_d   = acc_d[V_W+59:60];
            rem_d = rem_q - 1'b1;
          end
        end
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= (state_q == S_FIN);
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    ph_q  <= ph_d;
    v_q   <= v_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    if (state_q == S_IDLE && start_i) begin
      f_q   <= u[FRAC_W-1:0];
      pos_q <= u[LOGIT_W-1];
    end
    if (state_q == S_FIN) exp_o <= res;
  end

endmodule

// ===== design/smx_div.sv =====
// Restoring divider: rounded exp * 2^16 / sum, one quotient bit a cycle,
// saturated to 16 bits. Uses smx_pkg.
module smx_div import smx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [EXP_W-1:0]  exp_i,
  input  logic [SUM_W-1:0]  sum_i,
  output logic              done_o,
  output logic [PROB_W-1:0] prob_o
);

  logic               busy_q;
  logic [NUM_W-1:0]   rem_q;
  logic [SUM_W-1:0]   sum_q;
  logic [QUO_W-1:0]   quo_q, quo_d;
  logic [4:0]         j_q;
  logic [DIV_W-1:0]   shifted;
  logic               ge;

  assign shifted = DIV_W'(sum_q) << j_q;
  assign ge      = (DIV_W'(rem_q) >= shifted);

  always_comb begin
    quo_d = quo_q;
    if (ge) quo_d[j_q] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      done_o <= busy_q && (j_q == '0);
      if (start_i) busy_q <= 1'b1;
      else if (j_q == '0) busy_q <= 1'b0;
    end
  end

  // One compare and subtract per quotient bit, top bit first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {exp_i, {PROB_W{1'b0}}} + NUM_W'(sum_i >> 1);
      sum_q <= sum_i;
      quo_q <= '0;
      j_q   <= 5'(PROB_W);
    end else if (busy_q) begin
      quo_q <= quo_d;
      if (ge) rem_q <= rem_q - shifted[NUM_W-1:0];
      if (j_q != '0) j_q <= j_q - 1'b1;
      else if (sum_q == '0) prob_o <= '0;
      else prob_o <= quo_d[PROB_W] ? '1 : quo_d[PROB_W-1:0];
    end
  end

endmodule

// ===== design/softmax_vector_core.sv =====
// Channel   | valid       | stall        | payload
// input     | in_valid_i  | in_stall_o   | logit_i, last_in_i
// output    | out_valid_o | out_stall_i  | probability_o, last_out_o, overflow_o
//
// For each stored element the back end pops the queue, reads the table, forms
// up to 16 products by e or 1/e, four partial products each, on the shared
// multiplier, then writes the store. Dropped elements are popped and set overflow.
// Emitting each element takes a RAM read and 17 divider steps, plus any output
// stalls. A two-entry queue lets the input keep loading meanwhile.
// Reset is asynchronous and active low; the store needs no clearing.
// Top level of the softmax vector core. Uses smx_pkg, smx_front, smx_exp,
// smx_div and smx_ram.
module softmax_vector_core import smx_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [LOGIT_W-1:0] logit_i,
  input  logic               last_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PROB_W-1:0]  probability_o,
  output logic               last_out_o,
  output logic               overflow_o
);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_EXP  = 6'b000010,
    B_RD   = 6'b000100,
    B_RDW  = 6'b001000,
    B_DIV  = 6'b010000,
    B_OUT  = 6'b100000
  } back_state_e;

  back_state_e       state_q, state_d;
  logic              q_valid, q_pop;
  smx_entry_t        q_entry;
  logic              exp_start, exp_done;
  logic [EXP_W-1:0]  exp_val;
  logic              div_start, div_done;
  logic [PROB_W-1:0] div_prob;
  logic [EXP_W-1:0]  rd_data;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  wcnt_q, wcnt_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic              ovf_q, ovf_d;
  logic              last_pend_q, last_pend_d;
  logic              ram_we;
  logic              load_out;

  smx_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .logit_i, .last_in_i,
    .q_valid_o (q_valid),
    .q_entry_o (q_entry),
    .q_pop_i   (q_pop)
  );

  smx_exp u_exp (
    .clk_i, .rst_ni,
    .start_i (exp_start),
    .logit_i (q_entry.logit),
    .done_o  (exp_done),
    .exp_o   (exp_val)
  );

  smx_ram #(.WIDTH(EXP_W), .DEPTH(MAX_LEN)) u_store (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (wcnt_q[IDX_W-1:0]),
    .wdata_i (exp_val),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_data)
  );

  smx_div u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .exp_i   (rd_data),
    .sum_i   (sum_q),
    .done_o  (div_done),
    .prob_o  (div_prob)
  );

  // Back end sequencer
  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    wcnt_d      = wcnt_q;
    rd_idx_d    = rd_idx_q;
    ovf_d       = ovf_q;
    last_pend_d = last_pend_q;
    q_pop       = 1'b0;
    exp_start   = 1'b0;
    div_start   = 1'b0;
    ram_we      = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_entry.drop) begin
            ovf_d = 1'b1;
            if (q_entry.last) begin
              rd_idx_d = '0;
              state_d  = B_RD;
            end
          end else begin
            exp_start   = 1'b1;
            last_pend_d = q_entry.last;
            state_d     = B_EXP;
          end
        end
      end
      B_EXP: begin
        if (exp_done) begin
          ram_we = 1'b1;
          sum_d  = sum_q + SUM_W'(exp_val);
          wcnt_d = wcnt_q + 1'b1;
          if (last_pend_q) begin
            rd_idx_d = '0;
            state_d  = B_RD;
          end else begin
            state_d = B_IDLE;
          end
        end
      end
      B_RD:  state_d = B_RDW;
      B_RDW: begin
        div_start = 1'b1;
        state_d   = B_DIV;
      end
      B_DIV: begin
        if (div_done) begin
          load_out = 1'b1;
          state_d  = B_OUT;
        end
      end
      B_OUT: begin
        if (!out_stall_i) begin
          if (last_out_o) begin
            sum_d   = '0;
            wcnt_d  = '0;
            ovf_d   = 1'b0;
            state_d = B_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
            state_d  = B_RD;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign out_valid_o = (state_q == B_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      sum_q       <= '0;
      wcnt_q      <= '0;
      rd_idx_q    <= '0;
      ovf_q       <= 1'b0;
      last_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      wcnt_q      <= wcnt_d;
      rd_idx_q    <= rd_idx_d;
      ovf_q       <= ovf_d;
      last_pend_q <= last_pend_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      probability_o <= div_prob;
      last_out_o    <= (CNT_W'(rd_idx_q) + 1'b1 == wcnt_q);
      overflow_o    <= ovf_q;
    end
  end

endmodule

// ===== design/smx_checker.sv =====
// Port-level checker for softmax_vector_core and its bind statement.
// Depends on softmax_vector_core_macros.svh.
`include "softmax_vector_core_macros.svh"

module smx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] probability_o,
  input logic        last_out_o,
  input logic        overflow_o
);

  // A stalled result stays offered
  `SMX_ASSERT_NEXT(a_valid_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // A stalled result keeps its value
  `SMX_ASSERT_NEXT(a_data_hold, out_valid_o && out_stall_i, $stable(probability_o) && $stable(last_out_o) && $stable(overflow_o), "stalled result changed")

  // Each result needs a fresh store read, so transactions never follow back to back
  `SMX_ASSERT_NEXT(a_out_gap, out_valid_o && !out_stall_i, !out_valid_o, "results delivered back to back")

endmodule

bind softmax_vector_core smx_checker u_smx_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .probability_o, .last_out_o, .overflow_o
);
